@@ design/round_robin_task_queue_unit_assert.svh @@
// assertion macros shared by the scheduler modules
// both expect clk and arst_n in scope
`ifndef ROUND_ROBIN_TASK_QUEUE_UNIT_ASSERT_SVH
`define ROUND_ROBIN_TASK_QUEUE_UNIT_ASSERT_SVH

`define RRTQ_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define RRTQ_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

@@ design/rrtq_pkg.sv @@
`timescale 1ns / 1ps

package rrtq_pkg;

	localparam int ID_W              = 4;
	localparam int FUNC_W            = 3;
	localparam int EXIT_W            = 8;
	localparam int STATUS_W          = 2;
	localparam int QLEN_W            = 5;
	localparam int DEFAULT_MAX_TASKS = 16;

	localparam int S_TDATA_W = 16;
	localparam int M_TDATA_W = 16;
	localparam int M_PAD_W   = M_TDATA_W - (ID_W + STATUS_W + 1 + QLEN_W);

	localparam logic [FUNC_W-1:0] FUNC_CREATE  = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_ADD     = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_KILL    = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_PAUSE   = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_RESTART = 3'd4;
	localparam logic [FUNC_W-1:0] FUNC_PICK    = 3'd5;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_BAD     = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_NO_ID   = 2'd3;

	typedef enum logic [1:0] {
		MODE_INIT,
		MODE_RUNNING,
		MODE_WAITING,
		MODE_STOPPED
	} mode_t;

	typedef enum logic [2:0] {
		Q_IDLE,
		Q_APPEND,
		Q_MARK,
		Q_STEP,
		Q_ROTATE
	} q_op_t;

	typedef struct packed {
		q_op_t            op;
		logic [ID_W-1:0]  id;
	} q_cmd_t;

	typedef struct packed {
		logic             any_hole;
		logic [ID_W-1:0]  head_id;
	} q_stat_t;

	// only ids that fit the id field can ever enter the queue
	function automatic int queue_depth(int max_tasks);
		return (max_tasks < (2 ** ID_W)) ? max_tasks : (2 ** ID_W);
	endfunction

endpackage

@@ design/rrtq_cell.sv @@
`timescale 1ns / 1ps

module rrtq_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rrtq_pkg::q_cmd_t            cmd,
	input  logic                        prev_valid,
	input  logic                        prev_hole,
	input  logic                        next_valid,
	input  logic [rrtq_pkg::ID_W-1:0]   next_id,
	input  logic [rrtq_pkg::ID_W-1:0]   head_id,
	output logic                        valid,
	output logic                        hole,
	output logic [rrtq_pkg::ID_W-1:0]   id
);

	logic                        valid_q;
	logic                        hole_q;
	logic [rrtq_pkg::ID_W-1:0]   id_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			hole_q  <= 1'b0;
		end else begin
			case (cmd.op)
				rrtq_pkg::Q_APPEND: begin
					if (!valid_q && prev_valid) begin
						valid_q <= 1'b1;
					end
				end
				rrtq_pkg::Q_MARK: begin
					if (valid_q && id_q == cmd.id) begin
						hole_q <= 1'b1;
					end
				end
				rrtq_pkg::Q_STEP: begin
					// hole walks one cell toward the tail, dropping off the end
					if (hole_q) begin
						hole_q <= 1'b0;
						if (!next_valid) begin
							valid_q <= 1'b0;
						end
					end else if (prev_hole && valid_q) begin
						hole_q <= 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			rrtq_pkg::Q_APPEND: begin
				if (!valid_q && prev_valid) begin
					id_q <= cmd.id;
				end
			end
			rrtq_pkg::Q_STEP: begin
				if (hole_q && next_valid) begin
					id_q <= next_id;
				end
			end
			rrtq_pkg::Q_ROTATE: begin
				if (valid_q) begin
					id_q <= next_valid ? next_id : head_id;
				end
			end
			default: begin
			end
		endcase
	end

	assign valid = valid_q;
	assign hole  = hole_q;
	assign id    = id_q;

endmodule

@@ design/rrtq_ctrl.sv @@
`timescale 1ns / 1ps
`include "round_robin_task_queue_unit_assert.svh"

module rrtq_ctrl #(
	parameter int MAX_TASKS = rrtq_pkg::DEFAULT_MAX_TASKS,
	localparam int DEPTH    = rrtq_pkg::queue_depth(MAX_TASKS),
	localparam int LEN_W    = $clog2(DEPTH + 1)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [rrtq_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rrtq_pkg::M_TDATA_W-1:0]    m_tdata,
	output rrtq_pkg::q_cmd_t                  q_cmd,
	input  rrtq_pkg::q_stat_t                 q_stat,
	output logic [LEN_W-1:0]                  run_length
);

	localparam int IDX_W  = $clog2(DEPTH);
	localparam int NID_W  = $clog2(MAX_TASKS + 1);
	localparam int ID_LO  = rrtq_pkg::FUNC_W;
	localparam int ID_HI  = rrtq_pkg::FUNC_W + rrtq_pkg::ID_W - 1;
	localparam int ST_LO  = rrtq_pkg::ID_W;
	localparam int ST_HI  = rrtq_pkg::ID_W + rrtq_pkg::STATUS_W - 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_REMOVE,
		S_APPEND,
		S_FINISH
	} state_t;

	state_t                                state_q;
	logic [rrtq_pkg::FUNC_W-1:0]           func_q;
	logic [rrtq_pkg::ID_W-1:0]             id_q;
	rrtq_pkg::mode_t                       mode_q [DEPTH];
	logic [LEN_W-1:0]                      len_q;
	logic [NID_W-1:0]                      next_id_q;
	logic [rrtq_pkg::ID_W-1:0]             chosen_q;
	logic [rrtq_pkg::STATUS_W-1:0]         status_q;
	logic                                  resched_q;
	logic                                  append_q;
	logic                                  hole_seen_q;
	logic                                  m_tvalid_q;
	logic [rrtq_pkg::M_TDATA_W-1:0]        m_tdata_q;

	logic                                  id_ok;
	logic [IDX_W-1:0]                      id_idx;
	logic [IDX_W-1:0]                      nid_idx;
	rrtq_pkg::mode_t                       cur_mode;
	logic                                  create_ok;
	logic                                  create_slot;

	assign id_ok       = int'(id_q) < MAX_TASKS;
	assign id_idx      = id_q[IDX_W-1:0];
	assign nid_idx     = next_id_q[IDX_W-1:0];
	assign cur_mode    = mode_q[id_idx];
	assign create_ok   = int'(next_id_q) < MAX_TASKS;
	assign create_slot = int'(next_id_q) < DEPTH;

	always_comb begin
		q_cmd.op = rrtq_pkg::Q_IDLE;
		q_cmd.id = id_q;
		case (state_q)
			S_EXEC: begin
				case (func_q)
					rrtq_pkg::FUNC_ADD, rrtq_pkg::FUNC_KILL: begin
						if (id_ok) begin
							q_cmd.op = rrtq_pkg::Q_MARK;
						end
					end
					rrtq_pkg::FUNC_PAUSE: begin
						if (id_ok && cur_mode == rrtq_pkg::MODE_RUNNING) begin
							q_cmd.op = rrtq_pkg::Q_MARK;
						end
					end
					rrtq_pkg::FUNC_PICK: begin
						if (len_q != '0) begin
							q_cmd.op = rrtq_pkg::Q_ROTATE;
						end
					end
					default: begin
					end
				endcase
			end
			S_REMOVE: begin
				if (q_stat.any_hole) begin
					q_cmd.op = rrtq_pkg::Q_STEP;
				end
			end
			S_APPEND: begin
				if (len_q != LEN_W'(DEPTH)) begin
					q_cmd.op = rrtq_pkg::Q_APPEND;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			func_q      <= '0;
			id_q        <= '0;
			for (int i = 0; i < DEPTH; i++) begin
				mode_q[i] <= rrtq_pkg::MODE_INIT;
			end
			len_q       <= '0;
			next_id_q   <= '0;
			chosen_q    <= '0;
			status_q    <= rrtq_pkg::STATUS_OK;
			resched_q   <= 1'b0;
			append_q    <= 1'b0;
			hole_seen_q <= 1'b0;
			m_tvalid_q  <= 1'b0;
			m_tdata_q   <= '0;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_FINISH) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						func_q      <= s_tdata[rrtq_pkg::FUNC_W-1:0];
						id_q        <= s_tdata[ID_HI:ID_LO];
						chosen_q    <= '0;
						status_q    <= rrtq_pkg::STATUS_OK;
						resched_q   <= 1'b0;
						append_q    <= 1'b0;
						hole_seen_q <= 1'b0;
						state_q     <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_FINISH;
					case (func_q)
						rrtq_pkg::FUNC_CREATE: begin
							if (create_ok) begin
								chosen_q  <= rrtq_pkg::ID_W'(next_id_q);
								next_id_q <= next_id_q + 1'b1;
								if (create_slot) begin
									mode_q[nid_idx] <= rrtq_pkg::MODE_INIT;
								end
							end else begin
								status_q <= rrtq_pkg::STATUS_NO_ID;
							end
						end
						rrtq_pkg::FUNC_ADD: begin
							if (id_ok) begin
								mode_q[id_idx] <= rrtq_pkg::MODE_RUNNING;
								append_q       <= 1'b1;
								state_q        <= S_REMOVE;
							end else begin
								status_q <= rrtq_pkg::STATUS_BAD;
							end
						end
						rrtq_pkg::FUNC_KILL: begin
							if (id_ok) begin
								mode_q[id_idx] <= rrtq_pkg::MODE_STOPPED;
								resched_q      <= 1'b1;
								state_q        <= S_REMOVE;
							end else begin
								status_q <= rrtq_pkg::STATUS_BAD;
							end
						end
						rrtq_pkg::FUNC_PAUSE: begin
							if (id_ok && cur_mode == rrtq_pkg::MODE_RUNNING) begin
								mode_q[id_idx] <= rrtq_pkg::MODE_WAITING;
								resched_q      <= 1'b1;
								state_q        <= S_REMOVE;
							end else begin
								status_q <= rrtq_pkg::STATUS_BAD;
							end
						end
						rrtq_pkg::FUNC_RESTART: begin
							if (id_ok && cur_mode == rrtq_pkg::MODE_WAITING) begin
								mode_q[id_idx] <= rrtq_pkg::MODE_RUNNING;
								state_q        <= S_APPEND;
							end else begin
								status_q <= rrtq_pkg::STATUS_BAD;
							end
						end
						rrtq_pkg::FUNC_PICK: begin
							if (len_q == '0) begin
								status_q <= rrtq_pkg::STATUS_EMPTY;
							end else begin
								chosen_q <= q_stat.head_id;
							end
						end
						default: begin
						end
					endcase
				end
				S_REMOVE: begin
					if (q_stat.any_hole) begin
						if (!hole_seen_q) begin
							len_q       <= len_q - 1'b1;
							hole_seen_q <= 1'b1;
						end
					end else begin
						state_q <= append_q ? S_APPEND : S_FINISH;
					end
				end
				S_APPEND: begin
					if (len_q != LEN_W'(DEPTH)) begin
						len_q <= len_q + 1'b1;
					end
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {{rrtq_pkg::M_PAD_W{1'b0}}, rrtq_pkg::QLEN_W'(len_q),
							resched_q, status_q, chosen_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_tready   = (state_q == S_IDLE);
	assign m_tvalid   = m_tvalid_q;
	assign m_tdata    = m_tdata_q;
	assign run_length = len_q;

	`RRTQ_ASSERT_ALWAYS(a_len_bound, len_q <= LEN_W'(DEPTH), "run length beyond queue depth")
	`RRTQ_ASSERT_ALWAYS(a_next_id_bound, int'(next_id_q) <= MAX_TASKS, "next id overran")
	`RRTQ_ASSERT_IMPLIES(a_fail_no_id, m_tvalid_q && m_tdata_q[ST_HI:ST_LO] != rrtq_pkg::STATUS_OK,
		m_tdata_q[rrtq_pkg::ID_W-1:0] == '0, "failed request carries a task id")

endmodule

@@ design/round_robin_task_queue_unit.sv @@
// round robin task scheduler
// s_* channel: one scheduler request per transfer (create, add, kill, pause,
// restart, pick); m_* channel: exactly one response per request, in order
// requests are handled one at a time; s_tready is high only while idle
// create, pick, unknown and rejected requests pass through the execute and finish
// states (a successful restart also through append); the next request is taken
// once the response is registered; add, kill and pause also pass through the
// remove state until the task's old slot has left the queue, and leave it at once
// when the task is not queued; the run queue is a row of cells and a removed slot
// walks to the tail one cell per cycle, add then appends the task before finishing
// the response sits in an output register; a stalled m_tready only holds the
// finished response, and the scheduler waits in its finish state until the earlier one is taken
// reset clears all task modes, the run queue and the id counter; no clearing
// pass is needed, the first request can be taken right after reset
`timescale 1ns / 1ps
`include "round_robin_task_queue_unit_assert.svh"

module round_robin_task_queue_unit #(
	parameter int MAX_TASKS = rrtq_pkg::DEFAULT_MAX_TASKS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// func[2:0], task_id[6:3], exit_status[14:7], zero[15]
	input  logic [rrtq_pkg::S_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// chosen_id[3:0], status[5:4], resched_set[6], queue_length[11:7], zero[15:12]
	output logic [rrtq_pkg::M_TDATA_W-1:0]    m_tdata
);

	localparam int DEPTH = rrtq_pkg::queue_depth(MAX_TASKS);
	localparam int LEN_W = $clog2(DEPTH + 1);

	rrtq_pkg::q_cmd_t              q_cmd;
	rrtq_pkg::q_stat_t             q_stat;
	logic [LEN_W-1:0]              run_length;
	logic [DEPTH-1:0]              valid_vec;
	logic [DEPTH-1:0]              hole_vec;
	logic [rrtq_pkg::ID_W-1:0]     id_arr [DEPTH];

	rrtq_ctrl #(
		.MAX_TASKS (MAX_TASKS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.q_cmd      (q_cmd),
		.q_stat     (q_stat),
		.run_length (run_length)
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                        prev_valid;
		logic                        prev_hole;
		logic                        next_valid;
		logic [rrtq_pkg::ID_W-1:0]   next_id;

		if (i == 0) begin : g_head
			assign prev_valid = 1'b1;
			assign prev_hole  = 1'b0;
		end else begin : g_mid
			assign prev_valid = valid_vec[i-1];
			assign prev_hole  = hole_vec[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign next_valid = 1'b0;
			assign next_id    = '0;
		end else begin : g_body
			assign next_valid = valid_vec[i+1];
			assign next_id    = id_arr[i+1];
		end

		rrtq_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (q_cmd),
			.prev_valid (prev_valid),
			.prev_hole  (prev_hole),
			.next_valid (next_valid),
			.next_id    (next_id),
			.head_id    (id_arr[0]),
			.valid      (valid_vec[i]),
			.hole       (hole_vec[i]),
			.id         (id_arr[i])
		);
	end

	assign q_stat.any_hole = |hole_vec;
	assign q_stat.head_id  = id_arr[0];

	`RRTQ_ASSERT_ALWAYS(a_single_hole, $onehot0(hole_vec), "more than one hole in run queue")
	`RRTQ_ASSERT_ALWAYS(a_packed_queue, (valid_vec & (valid_vec + DEPTH'(1))) == '0,
		"run queue cells not packed from the head")
	`RRTQ_ASSERT_IMPLIES(a_len_matches, !q_stat.any_hole,
		$countones(valid_vec) == int'(run_length), "run length disagrees with cells")

endmodule
